// File: design/ncq_pkg.sv
// shared types, constants and the absolute difference helper of the nearest codeword colour quantizer
`timescale 1ns / 1ps
package ncq_pkg;

  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_QUANTIZE = 1'b1;

  localparam int  PADDR_W       = 3;
  localparam logic REG_CODEBOOK_SIZE = 1'b0;

  localparam int  SIZE_W        = 9;
  localparam int  DIST_W        = 18;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic publish;
  } ncq_cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic out_free;
  } ncq_status_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/ncq_ctrl.sv
// controller state machine of the quantizer
`timescale 1ns / 1ps
module ncq_ctrl
  import ncq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_type,
  output logic        req_ready,
  input  ncq_status_t status,
  output ncq_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.load    = accept && (req_type == REQ_LOAD);
    cmd.start   = accept && (req_type == REQ_QUANTIZE);
    cmd.issue   = (state == ST_SEARCH);
    cmd.publish = (state == ST_FINISH) && status.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/ncq_datapath.sv
// palette memory, distance pipeline, running minimum and result register
`timescale 1ns / 1ps
module ncq_datapath
  import ncq_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int DEPTH       = 256,
  parameter int AW          = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  ncq_cmd_t           cmd,
  output ncq_status_t        status,
  input  logic [SIZE_W-1:0]  codebook_size,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         blue_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         red_in,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         best_index,
  output logic [7:0]         blue_out,
  output logic [7:0]         green_out,
  output logic [7:0]         red_out,
  output logic [DIST_W-1:0]  best_distance
);

  localparam logic [SIZE_W-1:0] CAP = SIZE_W'(DEPTH);

  logic [23:0]       mem [0:DEPTH-1];
  logic [7:0]        pix_b, pix_g, pix_r;
  logic [AW-1:0]     k;
  logic [SIZE_W-1:0] lim_size;
  logic [AW-1:0]     last_k;
  logic              load_ok;

  logic              v1, v2;
  logic [AW-1:0]     idx1, idx2;
  logic [23:0]       rd_word, word2;
  logic [15:0]       sq_b, sq_g, sq_r;
  logic [DIST_W-1:0] cand_dist;

  logic [DIST_W-1:0] best_d;
  logic [AW-1:0]     best_k;
  logic [23:0]       best_word;

  always_comb begin
    lim_size = codebook_size;
    if (lim_size == '0) lim_size = SIZE_W'(1);
    if (lim_size > CAP) lim_size = CAP;
  end

  assign last_k  = AW'(lim_size - SIZE_W'(1));
  assign load_ok = ({24'd0, entry_index} < 32'(MAX_ENTRIES));

  assign status.last     = (k == last_k);
  assign status.busy     = v1 || v2;
  assign status.out_free = !res_valid || res_ready;

  // palette store
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[entry_index[AW-1:0]] <= {red_in, green_in, blue_in};
    end
    rd_word <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_b <= blue_in;
      pix_g <= green_in;
      pix_r <= red_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (cmd.start) begin
        k <= '0;
      end else if (cmd.issue) begin
        k <= k + AW'(1);
      end
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= k;
    idx2 <= idx1;
    word2 <= rd_word;
    sq_b <= {8'd0, abs_diff(pix_b, rd_word[7:0])}   * {8'd0, abs_diff(pix_b, rd_word[7:0])};
    sq_g <= {8'd0, abs_diff(pix_g, rd_word[15:8])}  * {8'd0, abs_diff(pix_g, rd_word[15:8])};
    sq_r <= {8'd0, abs_diff(pix_r, rd_word[23:16])} * {8'd0, abs_diff(pix_r, rd_word[23:16])};
  end

  assign cand_dist = DIST_W'(sq_b) + DIST_W'(sq_g) + DIST_W'(sq_r);

  // running minimum, lowest index wins on ties
  always_ff @(posedge clk) begin
    if (v2 && ((idx2 == '0) || (cand_dist < best_d))) begin
      best_d    <= cand_dist;
      best_k    <= idx2;
      best_word <= word2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.publish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      best_index    <= 8'(best_k);
      blue_out      <= best_word[7:0];
      green_out     <= best_word[15:8];
      red_out       <= best_word[23:16];
      best_distance <= best_d;
    end
  end

endmodule

// File: design/nearest_codeword_color_quantizer.sv
// top level of the nearest codeword colour quantizer
// a load item writes one palette entry and gives no result; the next item can be taken in the cycle after
// a quantize item compares the pixel with palette entries 0 to codebook_size - 1 (at least 1, at most DEPTH)
// one palette entry is read per cycle from the single read port of the palette memory
// a new item is taken only after the quantize result has been published
// synchronous reset clears control and sets codebook_size to 1; palette is undefined
`timescale 1ns / 1ps
module nearest_codeword_color_quantizer
  import ncq_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               req_type,
  input  logic [7:0]         entry_index,
  input  logic [7:0]         blue_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         red_in,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         best_index,
  output logic [7:0]         blue_out,
  output logic [7:0]         green_out,
  output logic [7:0]         red_out,
  output logic [DIST_W-1:0]  best_distance
);

  localparam int DEPTH = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int AW    = $clog2(DEPTH);

  logic [SIZE_W-1:0] codebook_size;
  ncq_cmd_t          cmd;
  ncq_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codebook_size <= SIZE_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_CODEBOOK_SIZE)) begin
      codebook_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CODEBOOK_SIZE) ? {23'd0, codebook_size} : 32'd0;

  ncq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ncq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DEPTH       (DEPTH),
    .AW          (AW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .codebook_size (codebook_size),
    .entry_index   (entry_index),
    .blue_in       (blue_in),
    .green_in      (green_in),
    .red_in        (red_in),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .best_index    (best_index),
    .blue_out      (blue_out),
    .green_out     (green_out),
    .red_out       (red_out),
    .best_distance (best_distance)
  );

endmodule

// File: design/ncq_checker.sv
// port checker for the quantizer, bound to the top level
`timescale 1ns / 1ps
module ncq_checker
  import ncq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               req_type,
  input logic               res_valid,
  input logic               res_ready,
  input logic [7:0]         best_index,
  input logic [DIST_W-1:0]  best_distance
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(best_index) && $stable(best_distance))
    else $error("stalled result changed");

  a_busy_after_pixel: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type == REQ_QUANTIZE) |=> !req_ready)
    else $error("item taken during search");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> best_distance <= DIST_W'(195075))
    else $error("distance out of range");

endmodule

bind nearest_codeword_color_quantizer ncq_checker u_checker (.*);
